FILE: rtl/sdr_pkg.sv
// Package for the signed divider: widths, command codes, controller states
// and the command/status structs between controller and datapath.
// No dependencies.
package sdr_pkg;

   localparam int WORD_W = 32;
   localparam int CNT_W  = $clog2(WORD_W);

   // Input item command codes
   localparam logic CMD_LOAD_DIVISOR = 1'b0;
   localparam logic CMD_EVALUATE     = 1'b1;

   // Operation mode codes
   localparam logic MODE_REMAINDER = 1'b0;
   localparam logic MODE_QUOTIENT  = 1'b1;

   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

   typedef enum logic [1:0] {
      SDR_IDLE,
      SDR_CALC,
      SDR_FIX
   } sdr_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load_div;
      logic start;
      logic step;
      logic finish;
   } sdr_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic last_step;
      logic out_blocked;
   } sdr_status_type;

endpackage

FILE: rtl/sdr_ctrl.sv
// Controller state machine of the signed divider.
// Depends on sdr_pkg for the state enum and command/status structs.
module sdr_ctrl import sdr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_command,
   output logic           req_ready,
   input  sdr_status_type status,
   output sdr_cmd_type    cmd
);

   sdr_state_type state_ff;
   sdr_state_type state_in;

   // Hold the current state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SDR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SDR_IDLE: begin
            if (req_valid && req_command == CMD_EVALUATE) begin
               state_in = SDR_CALC;
            end
         end
         SDR_CALC: begin
            if (status.last_step) begin
               state_in = SDR_FIX;
            end
         end
         SDR_FIX: begin
            if (!status.out_blocked) begin
               state_in = SDR_IDLE;
            end
         end
         default: state_in = SDR_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd.load_div = 1'b0;
      cmd.start    = 1'b0;
      cmd.step     = 1'b0;
      cmd.finish   = 1'b0;
      case (state_ff)
         SDR_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_div = req_valid && req_command == CMD_LOAD_DIVISOR;
            cmd.start    = req_valid && req_command == CMD_EVALUATE;
         end
         SDR_CALC: begin
            cmd.step = 1'b1;
         end
         SDR_FIX: begin
            cmd.finish = !status.out_blocked;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

FILE: rtl/sdr_dpath.sv
// Datapath of the signed divider: held divisor, mode register, radix-2
// restoring divide on magnitudes, sign fix-up and output register.
// Depends on sdr_pkg.
module sdr_dpath import sdr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [WORD_W-1:0] req_operand_value,
   input  logic                     csr_write_enable,
   input  logic                     csr_write_data,
   input  sdr_cmd_type              cmd,
   output sdr_status_type           status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_answer
);

   logic [WORD_W-1:0] divisor_ff;
   logic              mode_ff;
   logic [WORD_W-1:0] dmag_ff;
   logic              dzero_ff;
   logic              a_neg_ff;
   logic              q_neg_ff;
   logic [WORD_W-1:0] rem_ff;
   logic [WORD_W-1:0] quo_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_answer_ff;

   logic [WORD_W-1:0] operand_u;
   logic [WORD_W-1:0] operand_mag;
   logic [WORD_W-1:0] divisor_mag;
   logic [WORD_W:0]   shifted;
   logic [WORD_W:0]   trial;
   logic [WORD_W-1:0] rem_in;
   logic [WORD_W-1:0] quo_in;
   logic [WORD_W-1:0] result_mag;
   logic              result_neg;
   logic [WORD_W-1:0] answer_in;
   logic              rsp_valid_in;

   // Magnitudes of the incoming operand and the held divisor
   assign operand_u   = WORD_W'(req_operand_value);
   assign operand_mag = operand_u[WORD_W-1] ? (~operand_u + 1'b1) : operand_u;
   assign divisor_mag = divisor_ff[WORD_W-1] ? (~divisor_ff + 1'b1) : divisor_ff;

   // One restoring step: shift in the next dividend bit, trial subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[WORD_W-1]};
      trial   = shifted - {1'b0, dmag_ff};
      if (trial[WORD_W]) begin
         rem_in = shifted[WORD_W-1:0];
         quo_in = {quo_ff[WORD_W-2:0], 1'b0};
      end else begin
         rem_in = trial[WORD_W-1:0];
         quo_in = {quo_ff[WORD_W-2:0], 1'b1};
      end
   end

   // Sign fix-up; a zero divisor gives zero in both modes
   always_comb begin
      if (mode_ff == MODE_QUOTIENT) begin
         result_mag = quo_ff;
         result_neg = q_neg_ff;
      end else begin
         result_mag = rem_ff;
         result_neg = a_neg_ff;
      end
      if (dzero_ff) begin
         answer_in = '0;
      end else if (result_neg) begin
         answer_in = ~result_mag + 1'b1;
      end else begin
         answer_in = result_mag;
      end
   end

   // Control registers: divisor, mode, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff   <= '0;
         mode_ff      <= MODE_QUOTIENT;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_div) begin
            divisor_ff <= operand_u;
         end
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Drop the result once transferred, load on finish
   assign rsp_valid_in = cmd.finish ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   // Divide registers: load on start, advance one bit per step
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         dmag_ff  <= divisor_mag;
         dzero_ff <= (divisor_ff == '0);
         a_neg_ff <= operand_u[WORD_W-1];
         q_neg_ff <= operand_u[WORD_W-1] ^ divisor_ff[WORD_W-1];
         rem_ff   <= '0;
         quo_ff   <= operand_mag;
         count_ff <= '0;
      end else if (cmd.step) begin
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         count_ff <= count_ff + 1'b1;
      end
      if (cmd.finish) begin
         rsp_answer_ff <= answer_in;
      end
   end

   assign status.last_step   = (count_ff == LAST_STEP);
   assign status.out_blocked = rsp_valid_ff && !rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_answer = signed'(rsp_answer_ff);

endmodule

FILE: rtl/signed_divide_remainder.sv
// Top level of the 32-bit signed divider (quotient or remainder).
// Depends on sdr_pkg, sdr_ctrl and sdr_dpath.
//
//   port group | direction | handshake          | payload
//   req_       | in        | req_valid/req_ready | req_command, req_operand_value
//   rsp_       | out       | rsp_valid/rsp_ready | rsp_answer
//   csr_       | in        | csr_write_enable    | csr_write_data (operation mode)
//
// A divisor load gives no result. A dividend passes through a load,
// 32 restoring steps of the shared subtractor (one quotient bit each) and
// a sign fix-up into the output register.
// The next item is taken the cycle after the fix-up, while the result waits.
// Reset clears the held divisor to zero and sets quotient mode.
// A stalled result holds the fix-up stage until the output register frees.
module signed_divide_remainder import sdr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_command,
   input  logic signed [WORD_W-1:0] req_operand_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_answer,
   input  logic                     csr_write_enable,
   input  logic                     csr_write_data
);

   sdr_cmd_type    cmd;
   sdr_status_type status;

   sdr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   sdr_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_operand_value (req_operand_value),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_answer        (rsp_answer)
   );

endmodule

FILE: sim/signed_divide_remainder_tb.sv
// Self-checking testbench for signed_divide_remainder: divisor loads and dividends in both
// operation modes, with random idling, stalls and a long output hold-off.
// Depends on sdr_pkg and the signed_divide_remainder RTL.
module signed_divide_remainder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sdr_pkg::*;

   localparam logic [WORD_W-1:0] MINUS_ONE   = '1;
   localparam logic [WORD_W-1:0] MOST_NEG    = 32'h8000_0000;
   localparam logic [WORD_W-1:0] MOST_POS    = 32'h7fff_ffff;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int QUIET_LIMIT     = 5000;
   localparam int REPORT_CAP      = 50;

   // Expected answers, worked out from the held divisor and the current mode
   class divider_scoreboard;
      logic [WORD_W-1:0] divisor;
      logic              mode;
      logic [WORD_W-1:0] answers_due[$];
      int                mismatches;
      int                requests_seen;
      int                answers_checked;

      function new();
         divisor         = '0;
         mode            = MODE_QUOTIENT;
         mismatches      = 0;
         requests_seen   = 0;
         answers_checked = 0;
      endfunction

      function void set_mode(logic m);
         mode = m;
      endfunction

      // Truncating division on magnitudes, sign fixed up afterwards
      function logic [WORD_W-1:0] predict_answer(logic [WORD_W-1:0] dividend);
         logic [WORD_W-1:0] mag_a;
         logic [WORD_W-1:0] mag_d;
         logic [WORD_W-1:0] raw;
         logic              flip;
         mag_a = dividend[WORD_W-1] ? -dividend : dividend;
         mag_d = divisor[WORD_W-1] ? -divisor : divisor;
         if (mode == MODE_QUOTIENT) begin
            if (divisor == '0)
               return '0;
            raw  = mag_a / mag_d;
            flip = dividend[WORD_W-1] ^ divisor[WORD_W-1];
         end else begin
            if (divisor == '0 || divisor == MINUS_ONE)
               return '0;
            raw  = mag_a % mag_d;
            flip = dividend[WORD_W-1];
         end
         return flip ? -raw : raw;
      endfunction

      function void note_request(logic cmd, logic [WORD_W-1:0] value);
         requests_seen++;
         if (cmd == CMD_LOAD_DIVISOR)
            divisor = value;
         else
            answers_due.push_back(predict_answer(value));
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= REPORT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task check_answer(logic [WORD_W-1:0] got);
         logic [WORD_W-1:0] want;
         answers_checked++;
         if (answers_due.size() == 0) begin
            report_mismatch($sformatf("answer %h with nothing outstanding", got));
         end else begin
            want = answers_due.pop_front();
            if (got !== want)
               report_mismatch($sformatf("answer %h, expected %h", got, want));
         end
      endtask
   endclass

   logic                     clock             = 1'b0;
   logic                     reset             = 1'b1;
   logic                     req_valid         = 1'b0;
   logic                     req_ready;
   logic                     req_command       = CMD_LOAD_DIVISOR;
   logic signed [WORD_W-1:0] req_operand_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready         = 1'b0;
   logic signed [WORD_W-1:0] rsp_answer;
   logic                     csr_write_enable  = 1'b0;
   logic                     csr_write_data    = MODE_QUOTIENT;

   int   send_idle_pct    = 0;
   int   recv_stall_pct   = 0;
   logic hold_off_request = 1'b0;

   divider_scoreboard answers = new();

   signed_divide_remainder u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_answer        (rsp_answer),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always #1 clock = ~clock;

   // Observe every transfer and register write at the edge that takes it
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable)
            answers.set_mode(csr_write_data);
         if (req_valid && req_ready)
            answers.note_request(req_command, req_operand_value);
         if (rsp_valid && rsp_ready)
            answers.check_answer(rsp_answer);
      end
   end

   // Result side: random stalls, or a long hold-off when asked for
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request <= 1'b0;
            rsp_ready        <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Give up when nothing has moved for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("no transfer for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // Offer one item, idling first at random, and hold it until the transfer
   task automatic send_item(input logic cmd, input logic [WORD_W-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_operand_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Operands weighted towards small values, the extremes and mixed magnitudes
   function automatic logic [WORD_W-1:0] pick_operand();
      logic [WORD_W-1:0] w;
      case ($urandom_range(0, 9))
         0, 1, 2: w = $urandom;
         3, 4:    w = $urandom_range(0, 40) - 20;
         5: begin
            case ($urandom_range(0, 4))
               0:       w = '0;
               1:       w = 1;
               2:       w = MINUS_ONE;
               3:       w = MOST_NEG;
               default: w = MOST_POS;
            endcase
         end
         default: begin
            w = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1))
               w = -w;
         end
      endcase
      return w;
   endfunction

   task automatic send_random_items(input int count);
      logic cmd;
      repeat (count) begin
         cmd = ($urandom_range(0, 9) < 3) ? CMD_LOAD_DIVISOR : CMD_EVALUATE;
         send_item(cmd, pick_operand());
      end
   endtask

   // Drop valid, wait for every outstanding answer, then let the block settle
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers.answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input logic m, input int count, input int idle_pct,
                            input int stall_pct);
      drain_and_settle();
      write_mode(m);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      send_random_items(count);
   endtask

   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Quotient mode out of reset, starting with no divisor ever loaded
      send_item(CMD_EVALUATE, 7);
      send_item(CMD_LOAD_DIVISOR, MINUS_ONE);
      send_item(CMD_EVALUATE, MOST_NEG);
      send_item(CMD_EVALUATE, MOST_POS);
      send_item(CMD_LOAD_DIVISOR, 0);
      send_item(CMD_EVALUATE, -5);
      send_item(CMD_LOAD_DIVISOR, MOST_NEG);
      send_item(CMD_EVALUATE, MOST_NEG);
      send_item(CMD_EVALUATE, MOST_POS);
      send_item(CMD_LOAD_DIVISOR, MOST_POS);
      send_item(CMD_EVALUATE, MOST_NEG);
      send_item(CMD_LOAD_DIVISOR, -7);
      send_item(CMD_EVALUATE, 20);
      send_item(CMD_EVALUATE, -20);

      // Remainder mode: sign follows the dividend, zero and minus one divisors give 0
      drain_and_settle();
      write_mode(MODE_REMAINDER);
      send_item(CMD_EVALUATE, -20);
      send_item(CMD_EVALUATE, 20);
      send_item(CMD_LOAD_DIVISOR, MINUS_ONE);
      send_item(CMD_EVALUATE, MOST_NEG);
      send_item(CMD_LOAD_DIVISOR, 0);
      send_item(CMD_EVALUATE, 5);
      send_item(CMD_LOAD_DIVISOR, MOST_NEG);
      send_item(CMD_EVALUATE, MOST_POS);
      send_item(CMD_EVALUATE, MOST_NEG);

      // Random traffic under each idling pattern, alternating the mode
      run_phase(MODE_QUOTIENT, 150, 0, 0);
      run_phase(MODE_REMAINDER, 150, 50, 0);
      run_phase(MODE_QUOTIENT, 150, 0, 50);
      run_phase(MODE_REMAINDER, 150, 11, 11);

      // Hold the result side off while items keep coming, so the input backs up
      drain_and_settle();
      write_mode(MODE_QUOTIENT);
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      hold_off_request <= 1'b1;
      send_random_items(75);
      hold_off_request <= 1'b1;
      send_random_items(75);
      drain_and_settle();

      $display("%0d requests, %0d answers checked in quotient and remainder modes,",
               answers.requests_seen, answers.answers_checked);
      $display("with sender idling, result stalls and a %0d-cycle result hold-off",
               HOLD_OFF_CYCLES);
      if (answers.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: sim.f
rtl/sdr_pkg.sv
rtl/sdr_ctrl.sv
rtl/sdr_dpath.sv
rtl/signed_divide_remainder.sv
sim/signed_divide_remainder_tb.sv
